/* src/lavm_pkg.sv */
// lavm_pkg: shared types and constants of the look-at view matrix block
// depends on nothing; used by lavm_norm and look_at_view_matrix_top
`timescale 1ns / 1ps

package lavm_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned AXIS_FRAC  = 30;
  localparam int unsigned VEC_W      = 64;
  localparam int unsigned MAG_W      = 30;
  localparam int unsigned SHIFT_W    = VEC_W + MAG_W - 1;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned SQW        = 63;
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned QUO_W      = 31;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned DIVD_W     = 61;
  localparam int unsigned NORM_LAT   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int unsigned CROSS_LAT  = 2;
  localparam int unsigned DOT_LAT    = 3;
  localparam int unsigned PIPE_LAT   = 1 + 3 * NORM_LAT + 2 * CROSS_LAT + DOT_LAT;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [2:0][WORD_W-1:0]   word3_t;
  typedef logic [2:0][VEC_W-1:0]    vec3_t;

  typedef struct packed {
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;
    word_t up_x;
    word_t up_y;
    word_t up_z;
  } lavm_in_t;

  typedef struct packed {
    word_t side_x;
    word_t side_y;
    word_t side_z;
    word_t side_shift;
    word_t lift_x;
    word_t lift_y;
    word_t lift_z;
    word_t lift_shift;
    word_t view_x;
    word_t view_y;
    word_t view_z;
    word_t view_shift;
  } lavm_out_t;

endpackage

/* src/lavm_norm.sv */
// lavm_norm: pipelined vector normaliser, 64-bit components in, Q2.30 axis out
// depends on lavm_pkg; advances when en_i is high
`timescale 1ns / 1ps

module lavm_norm (
  input  logic           clk_i,
  input  logic           en_i,
  input  lavm_pkg::vec3_t  vec_i,
  output lavm_pkg::word3_t axis_o
);
  import lavm_pkg::*;

  function automatic logic [2:0] msb3(input logic [7:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  // magnitude stage
  logic [2:0]            sg0_q;
  logic [2:0][VEC_W-1:0] mag0_q;
  // leading one, byte level
  logic [2:0]            sg1_q;
  logic [2:0][VEC_W-1:0] mag1_q;
  logic [7:0]            nz1_q;
  logic [7:0][2:0]       lp1_q;
  // leading one position
  logic [2:0]            sg2_q;
  logic [2:0][VEC_W-1:0] mag2_q;
  logic [POS_W-1:0]      p2_q;
  logic                  z2_q;
  // aligned magnitudes
  logic [2:0]            sg3_q;
  logic [2:0][MAG_W-1:0] a3_q;
  logic                  z3_q;
  // squares
  logic [2:0]            sg4_q;
  logic [2:0][MAG_W-1:0] a4_q;
  logic [2:0][SQ_W-1:0]  sq4_q;
  logic                  z4_q;

  // square root pipe, index 0 holds the sum of squares
  logic [SQW-1:0]        sx_q  [SQRT_STEPS+1];
  logic [SQW-1:0]        sr_q  [SQRT_STEPS+1];
  logic [2:0][MAG_W-1:0] sa_q  [SQRT_STEPS+1];
  logic                  sz_q  [SQRT_STEPS+1];
  logic [2:0]            ssg_q [SQRT_STEPS+1];
  logic [SQW-1:0]        sx_d  [SQRT_STEPS];
  logic [SQW-1:0]        sr_d  [SQRT_STEPS];
  logic [SQW-1:0]        sb    [SQRT_STEPS];
  logic [SQW-1:0]        st    [SQRT_STEPS];

  // divider pipe, index 0 holds the rounded dividends
  logic [2:0][DIVD_W-1:0] rem_q [DIV_STEPS+1];
  logic [2:0][QUO_W-1:0]  quo_q [DIV_STEPS+1];
  logic [ROOT_W-1:0]      dvs_q [DIV_STEPS+1];
  logic                   dz_q  [DIV_STEPS+1];
  logic [2:0]             dsg_q [DIV_STEPS+1];
  logic [2:0][DIVD_W-1:0] rem_d [DIV_STEPS];
  logic [2:0][QUO_W-1:0]  quo_d [DIV_STEPS];
  logic [DIVD_W-1:0]      dsub  [DIV_STEPS];

  logic [2:0][VEC_W-1:0]  mag_d;
  logic [VEC_W-1:0]       orw;
  logic [7:0]             nz_d;
  logic [7:0][2:0]        lp_d;
  logic [POS_W-1:0]       p_d;
  logic [2:0][MAG_W-1:0]  a_d;
  logic [SHIFT_W-1:0]     wide;
  logic [ROOT_W-1:0]      root;
  logic [2:0][DIVD_W-1:0] dvd_d;
  word3_t                 axis_d;
  logic [WORD_W-1:0]      qext;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][VEC_W-1] ? (~vec_i[i] + VEC_W'(1)) : vec_i[i];
    end
    orw = mag0_q[0] | mag0_q[1] | mag0_q[2];
    for (int b = 0; b < 8; b++) begin
      nz_d[b] = |orw[8*b +: 8];
      lp_d[b] = msb3(orw[8*b +: 8]);
    end
    p_d = '0;
    for (int b = 0; b < 8; b++) begin
      if (nz1_q[b]) p_d = {3'(b), lp1_q[b]};
    end
    wide = '0;
    for (int i = 0; i < 3; i++) begin
      wide   = {mag2_q[i], {(MAG_W-1){1'b0}}} >> p2_q;
      a_d[i] = wide[MAG_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sb[k] = SQW'(1) << (2 * (SQRT_STEPS - 1 - k));
      st[k] = sr_q[k] + sb[k];
      if (sx_q[k] >= st[k]) begin
        sx_d[k] = sx_q[k] - st[k];
        sr_d[k] = (sr_q[k] >> 1) + sb[k];
      end else begin
        sx_d[k] = sx_q[k];
        sr_d[k] = sr_q[k] >> 1;
      end
    end
  end

  assign root = sr_q[SQRT_STEPS][ROOT_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd_d[i] = (DIVD_W'(sa_q[SQRT_STEPS][i]) << AXIS_FRAC) + DIVD_W'(root >> 1);
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dsub[k] = DIVD_W'(dvs_q[k]) << (DIV_STEPS - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (rem_q[k][i] >= dsub[k]) begin
          rem_d[k][i] = rem_q[k][i] - dsub[k];
          quo_d[k][i] = {quo_q[k][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[k][i] = rem_q[k][i];
          quo_d[k][i] = {quo_q[k][i][QUO_W-2:0], 1'b0};
        end
      end
    end
    qext = '0;
    for (int i = 0; i < 3; i++) begin
      qext = WORD_W'(quo_q[DIV_STEPS][i]);
      if (dz_q[DIV_STEPS]) begin
        axis_d[i] = '0;
      end else if (dsg_q[DIV_STEPS][i]) begin
        axis_d[i] = WORD_W'(0) - qext;
      end else begin
        axis_d[i] = qext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sg0_q[i] <= vec_i[i][VEC_W-1];
      mag0_q <= mag_d;
      sg1_q  <= sg0_q;
      mag1_q <= mag0_q;
      nz1_q  <= nz_d;
      lp1_q  <= lp_d;
      sg2_q  <= sg1_q;
      mag2_q <= mag1_q;
      p2_q   <= p_d;
      z2_q   <= ~|nz1_q;
      sg3_q  <= sg2_q;
      a3_q   <= a_d;
      z3_q   <= z2_q;
      sg4_q  <= sg3_q;
      a4_q   <= a3_q;
      z4_q   <= z3_q;
      for (int i = 0; i < 3; i++) sq4_q[i] <= a3_q[i] * a3_q[i];
      sx_q[0]  <= SQW'(sq4_q[0]) + SQW'(sq4_q[1]) + SQW'(sq4_q[2]);
      sr_q[0]  <= '0;
      sa_q[0]  <= a4_q;
      sz_q[0]  <= z4_q;
      ssg_q[0] <= sg4_q;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sx_q[k+1]  <= sx_d[k];
        sr_q[k+1]  <= sr_d[k];
        sa_q[k+1]  <= sa_q[k];
        sz_q[k+1]  <= sz_q[k];
        ssg_q[k+1] <= ssg_q[k];
      end
      rem_q[0] <= dvd_d;
      quo_q[0] <= '0;
      dvs_q[0] <= root;
      dz_q[0]  <= sz_q[SQRT_STEPS];
      dsg_q[0] <= ssg_q[SQRT_STEPS];
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k+1] <= rem_d[k];
        quo_q[k+1] <= quo_d[k];
        dvs_q[k+1] <= dvs_q[k];
        dz_q[k+1]  <= dz_q[k];
        dsg_q[k+1] <= dsg_q[k];
      end
      axis_o <= axis_d;
    end
  end

endmodule

/* src/look_at_view_matrix_top.sv */
// Left-handed look-at view matrix, fully pipelined: one item accepted per cycle while the input
// is not stalled. Most of the latency comes from three normalisers in series, each a 31-step
// square root pipeline and a 31-step divider pipeline. An output register and a one-entry skid
// buffer sit at the result side; the input stalls only while the skid buffer holds a result.
// depends on lavm_pkg and lavm_norm
`timescale 1ns / 1ps

module look_at_view_matrix_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lavm_pkg::lavm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lavm_pkg::lavm_out_t out_data_o
);
  import lavm_pkg::*;

  localparam int unsigned UpLen   = NORM_LAT;
  localparam int unsigned ViewLen = 2 * (NORM_LAT + CROSS_LAT);
  localparam int unsigned ViewTap = NORM_LAT + CROSS_LAT - 1;
  localparam int unsigned SideLen = NORM_LAT + CROSS_LAT;
  localparam int unsigned EyeLen  = 3 * NORM_LAT + 2 * CROSS_LAT;
  localparam int unsigned AxLen   = DOT_LAT - 1;

  logic en;
  logic [PIPE_LAT-1:0] vld_q;

  word3_t              eye1_q, up1_q;
  logic [2:0][32:0]    dir1_q, dir_d;
  vec3_t               nv_in, ns_in, nl_in;
  word3_t              view, side, lift;

  word3_t              up_dl_q   [UpLen];
  word3_t              view_dl_q [ViewLen];
  word3_t              side_dl_q [SideLen];
  word3_t              eye_dl_q  [EyeLen];

  logic signed [5:0][63:0] cp1_q, cp1_d, cp2_q, cp2_d;
  logic [2:0][63:0]        cx1_q, cx2_q;

  logic signed [2:0][2:0][63:0] dp_q, dp_d;
  logic signed [2:0][63:0]      ds_q;
  logic [2:0][WORD_W-1:0]       sh_d;
  word3_t                       ax_dl_q [AxLen][3];
  word3_t                       eye_a, view_a, view_b, side_a;
  logic signed [63:0]           tv;
  logic signed [33:0]           rv;

  lavm_out_t res_q, res_d;
  lavm_out_t out_q, sk_q;
  logic      out_v_q, sk_v_q;

  assign en         = !sk_v_q;
  assign in_stall_o = sk_v_q;

  always_comb begin
    dir_d[0] = {in_data_i.target_x[31], in_data_i.target_x} - {in_data_i.eye_x[31], in_data_i.eye_x};
    dir_d[1] = {in_data_i.target_y[31], in_data_i.target_y} - {in_data_i.eye_y[31], in_data_i.eye_y};
    dir_d[2] = {in_data_i.target_z[31], in_data_i.target_z} - {in_data_i.eye_z[31], in_data_i.eye_z};
    for (int i = 0; i < 3; i++) nv_in[i] = {{(VEC_W-33){dir1_q[i][32]}}, dir1_q[i]};
  end

  lavm_norm u_norm_view (.clk_i, .en_i(en), .vec_i(nv_in), .axis_o(view));

  assign view_a = view_dl_q[ViewTap];
  assign view_b = view_dl_q[ViewLen-1];
  assign side_a = side_dl_q[SideLen-1];
  assign eye_a  = eye_dl_q[EyeLen-1];

  always_comb begin
    cp1_d[0] = $signed(up_dl_q[UpLen-1][1]) * $signed(view[2]);
    cp1_d[1] = $signed(up_dl_q[UpLen-1][2]) * $signed(view[1]);
    cp1_d[2] = $signed(up_dl_q[UpLen-1][2]) * $signed(view[0]);
    cp1_d[3] = $signed(up_dl_q[UpLen-1][0]) * $signed(view[2]);
    cp1_d[4] = $signed(up_dl_q[UpLen-1][0]) * $signed(view[1]);
    cp1_d[5] = $signed(up_dl_q[UpLen-1][1]) * $signed(view[0]);
    cp2_d[0] = $signed(view_a[1]) * $signed(side[2]);
    cp2_d[1] = $signed(view_a[2]) * $signed(side[1]);
    cp2_d[2] = $signed(view_a[2]) * $signed(side[0]);
    cp2_d[3] = $signed(view_a[0]) * $signed(side[2]);
    cp2_d[4] = $signed(view_a[0]) * $signed(side[1]);
    cp2_d[5] = $signed(view_a[1]) * $signed(side[0]);
    ns_in = cx1_q;
    nl_in = cx2_q;
  end

  lavm_norm u_norm_side (.clk_i, .en_i(en), .vec_i(ns_in), .axis_o(side));
  lavm_norm u_norm_lift (.clk_i, .en_i(en), .vec_i(nl_in), .axis_o(lift));

  // axis order in the dot stages: 0 side, 1 lift, 2 view
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp_d[0][i] = $signed(eye_a[i]) * $signed(side_a[i]);
      dp_d[1][i] = $signed(eye_a[i]) * $signed(lift[i]);
      dp_d[2][i] = $signed(eye_a[i]) * $signed(view_b[i]);
    end
    tv = '0;
    rv = '0;
    for (int a = 0; a < 3; a++) begin
      tv = 64'sd536870912 - ds_q[a];
      rv = 34'(tv >>> AXIS_FRAC);
      if (rv[33:31] != {3{rv[33]}}) begin
        sh_d[a] = rv[33] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        sh_d[a] = rv[31:0];
      end
    end
    res_d.side_x     = ax_dl_q[AxLen-1][0][0];
    res_d.side_y     = ax_dl_q[AxLen-1][0][1];
    res_d.side_z     = ax_dl_q[AxLen-1][0][2];
    res_d.side_shift = sh_d[0];
    res_d.lift_x     = ax_dl_q[AxLen-1][1][0];
    res_d.lift_y     = ax_dl_q[AxLen-1][1][1];
    res_d.lift_z     = ax_dl_q[AxLen-1][1][2];
    res_d.lift_shift = sh_d[1];
    res_d.view_x     = ax_dl_q[AxLen-1][2][0];
    res_d.view_y     = ax_dl_q[AxLen-1][2][1];
    res_d.view_z     = ax_dl_q[AxLen-1][2][2];
    res_d.view_shift = sh_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye1_q <= {in_data_i.eye_z, in_data_i.eye_y, in_data_i.eye_x};
      up1_q  <= {in_data_i.up_z, in_data_i.up_y, in_data_i.up_x};
      dir1_q <= dir_d;
      up_dl_q[0]   <= up1_q;
      eye_dl_q[0]  <= eye1_q;
      view_dl_q[0] <= view;
      side_dl_q[0] <= side;
      for (int k = 1; k < UpLen; k++)   up_dl_q[k]   <= up_dl_q[k-1];
      for (int k = 1; k < EyeLen; k++)  eye_dl_q[k]  <= eye_dl_q[k-1];
      for (int k = 1; k < ViewLen; k++) view_dl_q[k] <= view_dl_q[k-1];
      for (int k = 1; k < SideLen; k++) side_dl_q[k] <= side_dl_q[k-1];
      cp1_q    <= cp1_d;
      cx1_q[0] <= cp1_q[0] - cp1_q[1];
      cx1_q[1] <= cp1_q[2] - cp1_q[3];
      cx1_q[2] <= cp1_q[4] - cp1_q[5];
      cp2_q    <= cp2_d;
      cx2_q[0] <= cp2_q[0] - cp2_q[1];
      cx2_q[1] <= cp2_q[2] - cp2_q[3];
      cx2_q[2] <= cp2_q[4] - cp2_q[5];
      dp_q <= dp_d;
      for (int a = 0; a < 3; a++) ds_q[a] <= dp_q[a][0] + dp_q[a][1] + dp_q[a][2];
      ax_dl_q[0][0] <= side_a;
      ax_dl_q[0][1] <= lift;
      ax_dl_q[0][2] <= view_b;
      for (int k = 1; k < AxLen; k++) ax_dl_q[k] <= ax_dl_q[k-1];
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= vld_q[PIPE_LAT-1];
      end
    end else if (en && vld_q[PIPE_LAT-1]) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= sk_v_q ? sk_q : res_q;
    end else if (en && vld_q[PIPE_LAT-1]) begin
      sk_q <= res_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_skid_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q && !$past(sk_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid holds a result while the output register is empty");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |=> $stable(vld_q))
    else $error("pipeline moved while the skid entry was full");

endmodule
